### sv/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types and constants for the reciprocal rank fusion block.
// ----------------------------------------------------------------------------
package rrf_pkg;

    localparam int SCORE_BITS = 24;
    localparam int TOPK_BITS = 9;
    localparam int OFFS_BITS = 10;
    localparam int CFG_BITS = 10;
    localparam logic [SCORE_BITS-1:0] SCORE_MAX = 24'hFFFFFF;
    localparam logic [23:0] ONE_Q22 = 24'h400000;
    localparam logic [TOPK_BITS-1:0] DEFAULT_TOP_K = 9'd25;
    localparam logic [TOPK_BITS-1:0] MAX_TOP_K = 9'd256;
    localparam logic [OFFS_BITS-1:0] DEFAULT_OFFSET = 10'd60;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_TAKE  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic CFG_TOP_K = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [10:0] divisor;
    } div_req_t;

endpackage

### sv/reciprocal_rank_fusion_top.sv
// ----------------------------------------------------------------------------
// reciprocal_rank_fusion_top
// Fuses ranked id lists into a bounded candidate pool held in memory.
// ----------------------------------------------------------------------------
// Input beats (s_valid/s_ready) carry an action: add an id of a ranked list,
// take the next best candidate, or clear the pool. Only a take produces a
// result beat on m_valid/m_ready. Configuration writes use cfg_we/cfg_index/
// cfg_wdata and are taken at once; the user must write only while the block
// is idle, which the block itself does not enforce. One item is worked at a
// time. An add scans the pool memory one entry per cycle, then runs the serial
// divider for the term and writes the score back. A take scans the score and
// taken memories one entry per cycle. A clear is done in the idle state.
// Reset empties the pool through its count; memory contents are not cleared.
// The result sits in an output register; while the receiver stalls the block
// finishes nothing further but may accept the next item into the pipeline
// only after the result is taken.
// ----------------------------------------------------------------------------
module reciprocal_rank_fusion_top #(
    parameter int ID_BITS = 64,
    parameter int PER_LIST_LIMIT = 50,
    parameter int POOL_DEPTH = 150
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [63:0]                  s_node_id,
    input  logic                         s_first_of_list,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [63:0]                  m_best_id,
    output logic [rrf_pkg::SCORE_BITS-1:0] m_fused_score,
    output logic                         m_found,
    output logic                         m_last,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [rrf_pkg::CFG_BITS-1:0] cfg_wdata
);
    import rrf_pkg::*;

    localparam int PB = $clog2(POOL_DEPTH + 1);
    localparam int AB = $clog2(POOL_DEPTH);
    localparam int LB = $clog2(PER_LIST_LIMIT + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SRCH  = 8'b00000010,
        ST_DSTRT = 8'b00000100,
        ST_DWAIT = 8'b00001000,
        ST_WRITE = 8'b00010000,
        ST_SCAN  = 8'b00100000,
        ST_TFIN  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    // pool memories
    logic [ID_BITS-1:0]    mem_id   [POOL_DEPTH];
    logic [SCORE_BITS-1:0] mem_sc   [POOL_DEPTH];
    logic                  mem_tk   [POOL_DEPTH];
    logic [ID_BITS-1:0]    rd_id;
    logic [SCORE_BITS-1:0] rd_sc;
    logic                  rd_tk;
    logic [AB-1:0]         rd_addr;
    logic                  we_id, we_sc, we_tk;
    logic [AB-1:0]         wr_addr;
    logic [SCORE_BITS-1:0] wr_sc;
    logic                  wr_tk;

    state_t state_reg, state_next;
    logic [TOPK_BITS-1:0] topk_reg;
    logic [OFFS_BITS-1:0] offs_reg;
    logic [PB-1:0] count_reg, count_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic          aband_reg, aband_next;
    logic [8:0]    taken_reg, taken_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [PB-1:0] addr_reg, addr_next;   // issued read address
    logic [PB-1:0] cmp_reg, cmp_next;     // address of data now on rd_*
    logic          rdv_reg, rdv_next;
    logic [PB-1:0] hit_reg, hit_next;
    logic          have_reg, have_next;
    logic          isnew_reg, isnew_next;
    logic [SCORE_BITS-1:0] best_sc_reg, best_sc_next;
    logic [ID_BITS-1:0]    best_id_reg, best_id_next;
    logic [SCORE_BITS-1:0] base_reg, base_next;
    logic [63:0] o_id_reg, o_id_next;
    logic [SCORE_BITS-1:0] o_sc_reg, o_sc_next;
    logic o_found_reg, o_found_next, o_last_reg, o_last_next;
    logic [8:0] eff_topk;
    logic [OFFS_BITS-1:0] eff_offs;
    logic [10:0] dvs;
    div_req_t dreq;
    logic ddone;
    logic [23:0] dquo;
    logic [24:0] sum;

    always_ff @(posedge aclk) begin
        if (we_id) mem_id[wr_addr] <= id_reg;
        if (we_sc) mem_sc[wr_addr] <= wr_sc;
        if (we_tk) mem_tk[wr_addr] <= wr_tk;
        rd_id <= mem_id[rd_addr];
        rd_sc <= mem_sc[rd_addr];
        rd_tk <= mem_tk[rd_addr];
    end

    rrf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quotient(dquo));

    assign eff_topk = (topk_reg == '0) ? DEFAULT_TOP_K :
                      (topk_reg > MAX_TOP_K) ? MAX_TOP_K : topk_reg;
    assign eff_offs = (offs_reg == '0) ? DEFAULT_OFFSET : offs_reg;
    assign dvs = {1'b0, eff_offs} + 11'(pos_reg);
    assign sum = {1'b0, base_reg} + {1'b0, dquo};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            topk_reg <= DEFAULT_TOP_K;
            offs_reg <= DEFAULT_OFFSET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_TOP_K) topk_reg <= cfg_wdata[TOPK_BITS-1:0];
            else if (cfg_index == CFG_OFFSET) offs_reg <= cfg_wdata[OFFS_BITS-1:0];
        end
    end

    assign s_ready = state_reg[0];

    // sequencer: search, divide, write back, scan for best, hold the result
    always_comb begin
        state_next = state_reg;
        count_next = count_reg; pos_next = pos_reg; aband_next = aband_reg;
        taken_next = taken_reg; id_next = id_reg; addr_next = addr_reg;
        cmp_next = addr_reg; rdv_next = 1'b0; hit_next = hit_reg;
        have_next = have_reg; isnew_next = isnew_reg; best_sc_next = best_sc_reg;
        best_id_next = best_id_reg; base_next = base_reg;
        o_id_next = o_id_reg; o_sc_next = o_sc_reg;
        o_found_next = o_found_reg; o_last_next = o_last_reg;
        rd_addr = addr_reg[AB-1:0];
        we_id = 1'b0; we_sc = 1'b0; we_tk = 1'b0;
        wr_addr = hit_reg[AB-1:0]; wr_sc = base_reg; wr_tk = 1'b0;
        dreq.start = 1'b0;
        dreq.dividend = ONE_Q22 + 24'(dvs >> 1);
        dreq.divisor = dvs;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (action_t'(s_action))
                        ACT_ADD: begin
                            if (s_first_of_list || (!aband_reg &&
                                    pos_reg < LB'(PER_LIST_LIMIT))) begin
                                pos_next = s_first_of_list ? LB'(1) : pos_reg + LB'(1);
                                aband_next = 1'b0;
                                id_next = s_node_id[ID_BITS-1:0];
                                addr_next = '0; have_next = 1'b0;
                                state_next = ST_SRCH;
                            end
                        end
                        ACT_TAKE: begin
                            addr_next = '0; have_next = 1'b0;
                            if (taken_reg >= eff_topk) begin
                                o_id_next = '0; o_sc_next = '0;
                                o_found_next = 1'b0; o_last_next = 1'b0;
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_CLEAR: begin
                            count_next = '0; pos_next = '0;
                            aband_next = 1'b0; taken_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRCH: begin
                // pipelined compare of the entry read last cycle
                if (rdv_reg && !have_reg && rd_id == id_reg) begin
                    have_next = 1'b1; hit_next = cmp_reg; base_next = rd_sc;
                    isnew_next = 1'b0;
                end
                if (addr_reg < count_reg && !have_next) begin
                    addr_next = addr_reg + PB'(1);
                    rdv_next = 1'b1;
                end else if (!rdv_reg || have_next) begin
                    if (have_next) begin
                        state_next = ST_DSTRT;
                    end else if (count_reg >= PB'(POOL_DEPTH)) begin
                        aband_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        hit_next = count_reg; base_next = '0; isnew_next = 1'b1;
                        count_next = count_reg + PB'(1);
                        state_next = ST_DSTRT;
                    end
                end
            end
            ST_DSTRT: begin
                dreq.start = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (ddone) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                we_sc = 1'b1;
                wr_sc = sum[24] ? SCORE_MAX : sum[SCORE_BITS-1:0];
                we_id = isnew_reg; we_tk = isnew_reg; wr_tk = 1'b0;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (rdv_reg && !rd_tk && (!have_reg || rd_sc > best_sc_reg)) begin
                    have_next = 1'b1; hit_next = cmp_reg;
                    best_sc_next = rd_sc; best_id_next = rd_id;
                end
                if (addr_reg < count_reg) begin
                    addr_next = addr_reg + PB'(1);
                    rdv_next = 1'b1;
                end else if (!rdv_reg) begin
                    state_next = ST_TFIN;
                end
            end
            ST_TFIN: begin
                if (have_reg) begin
                    we_tk = 1'b1; wr_tk = 1'b1;
                    taken_next = taken_reg + 9'd1;
                    o_id_next = 64'(best_id_reg); o_sc_next = best_sc_reg;
                    o_found_next = 1'b1;
                    o_last_next = (taken_next >= eff_topk) ||
                                  (taken_next >= 9'(count_reg));
                end else begin
                    o_id_next = '0; o_sc_next = '0;
                    o_found_next = 1'b0; o_last_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0; pos_reg <= '0; aband_reg <= 1'b0; taken_reg <= '0;
            rdv_reg <= 1'b0; have_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next; pos_reg <= pos_next;
            aband_reg <= aband_next; taken_reg <= taken_next;
            rdv_reg <= rdv_next; have_reg <= have_next;
        end
        id_reg <= id_next; addr_reg <= addr_next; cmp_reg <= cmp_next;
        hit_reg <= hit_next; isnew_reg <= isnew_next; best_sc_reg <= best_sc_next;
        best_id_reg <= best_id_next; base_reg <= base_next;
        o_id_reg <= o_id_next; o_sc_reg <= o_sc_next;
        o_found_reg <= o_found_next; o_last_reg <= o_last_next;
    end

    assign m_valid = state_reg[7];
    assign m_best_id = o_id_reg;
    assign m_fused_score = o_sc_reg;
    assign m_found = o_found_reg;
    assign m_last = o_last_reg;
endmodule

### sv/rrf_div.sv
// ----------------------------------------------------------------------------
// rrf_div
// Restoring divider, one quotient bit per cycle, 24-bit dividend.
// ----------------------------------------------------------------------------
module rrf_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrf_pkg::div_req_t     req,
    output logic                  done,
    output logic [23:0]           quotient
);
    import rrf_pkg::*;

    logic [23:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [10:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [11:0] trial;

    // one shift-subtract step
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[10:0], quo_reg[23]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[22:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

### test/tb_reciprocal_rank_fusion_top.sv
// ----------------------------------------------------------------------------
// tb_reciprocal_rank_fusion_top
// Self-checking bench for the rank fusion block: drives add, take and clear
// beats with random gaps and stalls, predicts every take result and compares.
// ----------------------------------------------------------------------------
module tb_reciprocal_rank_fusion_top;
    import rrf_pkg::*;

    localparam int POOL_N = 150;
    localparam int LIST_MAX = 50;
    localparam int STALL_LIMIT = 20000;

    // expected take result
    typedef struct {
        logic [63:0] id;
        logic [23:0] score;
        logic        found;
        logic        last;
    } take_beat_t;

    // fusion predictor and queue of expected take results
    class fusion_board;
        logic [63:0] ids[POOL_N];
        logic [23:0] scores[POOL_N];
        bit          taken[POOL_N];
        int          count, pos, n_taken, errors, n_results;
        bit          abandoned;
        int          top_k, offset;
        take_beat_t  pending[$];

        function new();
            count = 0; pos = 0; n_taken = 0; abandoned = 0;
            errors = 0; n_results = 0; top_k = 25; offset = 60;
        endfunction

        function void set_reg(bit idx, int val);
            if (idx == CFG_TOP_K) top_k = val & 'h1ff;
            else offset = val & 'h3ff;
        endfunction

        function void note_input(action_t act, logic [63:0] id, bit first);
            int idx, d, term, sum, lim, best;
            bit have;
            take_beat_t r;
            case (act)
                ACT_ADD: begin
                    if (first) begin
                        pos = 0; abandoned = 0;
                    end
                    if (abandoned || pos >= LIST_MAX) return;
                    pos++;
                    idx = count;
                    for (int i = 0; i < count; i++)
                        if (ids[i] == id) begin
                            idx = i; break;
                        end
                    if (idx >= count) begin
                        if (count >= POOL_N) begin
                            abandoned = 1; return;
                        end
                        ids[idx] = id; scores[idx] = 0; taken[idx] = 0;
                        count++;
                    end
                    d = (offset == 0 ? 60 : offset) + pos;
                    term = ((1 << 22) + d / 2) / d;
                    sum = scores[idx] + term;
                    if (sum > 'hffffff) sum = 'hffffff;
                    scores[idx] = sum;
                end
                ACT_TAKE: begin
                    r = '{64'd0, 24'd0, 1'b0, 1'b0};
                    lim = top_k == 0 ? 25 : (top_k > 256 ? 256 : top_k);
                    have = 0; best = 0;
                    if (n_taken < lim) begin
                        for (int i = 0; i < count; i++) begin
                            if (taken[i]) continue;
                            if (!have || scores[i] > scores[best]) begin
                                best = i; have = 1;
                            end
                        end
                        if (have) begin
                            taken[best] = 1; n_taken++;
                            r = '{ids[best], scores[best], 1'b1,
                                  (n_taken >= lim || n_taken >= count)};
                        end
                    end
                    pending.push_back(r);
                end
                ACT_CLEAR: begin
                    count = 0; pos = 0; abandoned = 0; n_taken = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [63:0] id, logic [23:0] sc, logic f, logic l);
            take_beat_t e;
            n_results++;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++; return;
            end
            e = pending.pop_front();
            if (id !== e.id) begin
                $error("best_id exp %h got %h", e.id, id); errors++;
            end
            if (sc !== e.score) begin
                $error("fused_score exp %h got %h", e.score, sc); errors++;
            end
            if (f !== e.found) begin
                $error("found exp %b got %b", e.found, f); errors++;
            end
            if (l !== e.last) begin
                $error("last exp %b got %b", e.last, l); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0, aresetn = 0;
    logic        s_valid = 0, m_ready = 0, s_first_of_list = 0;
    logic [1:0]  s_action = ACT_NONE;
    logic [63:0] s_node_id = 0;
    logic        s_ready, m_valid, m_found, m_last;
    logic [63:0] m_best_id;
    logic [SCORE_BITS-1:0] m_fused_score;
    logic        cfg_we = 0, cfg_index = 0;
    logic [CFG_BITS-1:0] cfg_wdata = 0;

    fusion_board board = new();
    bit quiet = 0;
    int idle_cnt = 0;
    int n_items = 0;
    logic [63:0] id_bank[16];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    reciprocal_rank_fusion_top dut (.*);

    // result side: random stalls, check on each beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_best_id, m_fused_score, m_found, m_last);
            m_ready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("tb_reciprocal_rank_fusion_top: FAIL");
            $finish;
        end
    end

    // valid stays high after a beat until the next send or an idle gap
    task automatic send(action_t act, logic [63:0] id, bit first);
        if (!quiet && $urandom_range(99) < 14) begin
            s_valid <= 0;
            @(posedge aclk);
            while (!quiet && $urandom_range(99) < 14) @(posedge aclk);
        end
        s_valid <= 1; s_action <= act; s_node_id <= id; s_first_of_list <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(act, id, first);
        n_items++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(bit idx, int val);
        drain();
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= CFG_BITS'(val);
        @(posedge aclk);
        cfg_we <= 0;
        board.set_reg(idx, val);
    endtask

    function automatic logic [63:0] pick_id();
        if ($urandom_range(3) != 0) return id_bank[$urandom_range(15)];
        return {$urandom, $urandom};
    endfunction

    // one query: a few lists, takes, sometimes a no-op, then a clear
    task automatic run_query(int lists, int len, int takes);
        for (int l = 0; l < lists; l++)
            for (int r = 0; r < len; r++)
                send(ACT_ADD, pick_id(), r == 0);
        for (int t = 0; t < takes; t++) send(ACT_TAKE, 0, 0);
        if ($urandom_range(9) == 0) send(ACT_NONE, pick_id(), 1'($urandom_range(1)));
        send(ACT_CLEAR, pick_id(), 1'($urandom_range(1)));
    endtask

    initial begin
        int ph;
        for (int i = 0; i < 16; i++) id_bank[i] = {$urandom, $urandom};
        id_bank[0] = 64'd0;
        id_bank[1] = '1;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: take on empty pool, extremes, add before first entry
        send(ACT_TAKE, 0, 0);
        send(ACT_ADD, 64'd0, 0);
        send(ACT_ADD, '1, 0);
        send(ACT_ADD, '1, 1);
        send(ACT_NONE, 64'h5a5a, 1);
        send(ACT_TAKE, 0, 0);
        send(ACT_ADD, 64'd0, 1);
        send(ACT_TAKE, 0, 0);
        send(ACT_TAKE, 0, 0);
        send(ACT_CLEAR, 0, 0);
        // score saturation with rank_offset 1 and many repeats
        write_reg(CFG_OFFSET, 1);
        write_reg(CFG_TOP_K, 1);
        for (int i = 0; i < 8; i++) send(ACT_ADD, 64'hAAAA_5555_AAAA_5555, 1);
        send(ACT_TAKE, 0, 0);
        send(ACT_TAKE, 0, 0);
        send(ACT_CLEAR, 0, 0);
        // register zero means default
        write_reg(CFG_TOP_K, 0);
        write_reg(CFG_OFFSET, 0);

        // per-list limit and pool overflow with long lists, no idling
        write_reg(CFG_OFFSET, 1023);
        write_reg(CFG_TOP_K, 511);
        quiet = 1;
        for (int l = 0; l < 4; l++)
            for (int r = 0; r < 55; r++) send(ACT_ADD, {$urandom, $urandom}, r == 0);
        send(ACT_ADD, id_bank[2], 1);
        for (int t = 0; t < 4; t++) send(ACT_TAKE, 0, 0);
        send(ACT_CLEAR, 0, 0);
        quiet = 0;

        // random queries under varying settings
        ph = 0;
        while (n_items < 1500) begin
            quiet = (ph % 7 == 3);
            case (ph % 5)
                0: write_reg(CFG_TOP_K, $urandom_range(1, 8));
                1: write_reg(CFG_OFFSET, $urandom_range(1, 1023));
                2: write_reg(CFG_TOP_K, 256);
                3: write_reg(CFG_OFFSET, $urandom_range(1, 4));
                default: write_reg(CFG_TOP_K, $urandom_range(0, 511));
            endcase
            if ($urandom_range(4) == 0) write_reg(CFG_OFFSET, $urandom_range(0, 1023));
            run_query($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 10));
            ph++;
        end
        quiet = 0;

        drain();
        $display("covered %0d input beats and %0d take results over %0d random queries",
                 n_items, board.n_results, ph);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_reciprocal_rank_fusion_top: PASS");
        else
            $display("tb_reciprocal_rank_fusion_top: FAIL");
        $finish;
    end
endmodule
